// ===== hw/rtl/u8sd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int CP_W = 31;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [CP_W-1:0] cp_t;

    typedef struct packed {
        logic two;
        cp_t  cp1;
        cp_t  cp0;
    } res_entry_t;

    typedef struct packed {
        logic       valid;
        res_entry_t entry;
    } q_head_t;

endpackage

// ===== hw/rtl/u8sd_front.sv =====
// Front end: accepts text bytes, tracks the open sequence and forms result entries.
module u8sd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          text_byte,
    input  logic                final_byte,
    output logic                push,
    output u8sd_pkg::res_entry_t push_entry
);
    import u8sd_pkg::*;

    cp_t        acc_reg;
    cp_t        acc_next;
    logic [2:0] fl_reg;
    logic [2:0] fl_next;
    logic       open_reg;
    logic       open_next;
    logic [1:0] cnt;
    res_entry_t ent;

    always_comb
    begin
        logic [7:0] mask;
        logic [2:0] n;
        acc_next  = acc_reg;
        fl_next   = fl_reg;
        open_next = open_reg;
        cnt       = 2'd0;
        ent       = '0;
        mask      = 8'h01;
        n         = 3'd5;
        if (open_reg && text_byte[7:6] == 2'b10)
        begin
            acc_next = {acc_reg[CP_W-7:0], text_byte[5:0]};
            if (fl_reg != 3'd0)
            begin
                fl_next = fl_reg - 3'd1;
            end
            if (fl_next == 3'd0)
            begin
                ent.cp0   = acc_next;
                cnt       = 2'd1;
                open_next = 1'b0;
                acc_next  = '0;
            end
        end
        else
        begin
            if (open_reg)
            begin
                ent.cp0   = acc_reg;
                cnt       = 2'd1;
                open_next = 1'b0;
                fl_next   = 3'd0;
                acc_next  = '0;
            end
            if (!text_byte[7])
            begin
                if (cnt == 2'd0)
                begin
                    ent.cp0 = cp_t'(text_byte);
                end
                else
                begin
                    ent.cp1 = cp_t'(text_byte);
                end
                cnt = cnt + 2'd1;
            end
            else
            begin
                case (text_byte) inside
                    [8'hC0:8'hDF]:
                    begin
                        mask = 8'h1F;
                        n    = 3'd1;
                    end
                    [8'hE0:8'hEF]:
                    begin
                        mask = 8'h0F;
                        n    = 3'd2;
                    end
                    [8'hF0:8'hF7]:
                    begin
                        mask = 8'h07;
                        n    = 3'd3;
                    end
                    [8'hF8:8'hFB]:
                    begin
                        mask = 8'h03;
                        n    = 3'd4;
                    end
                    default:
                    begin
                        mask = 8'h01;
                        n    = 3'd5;
                    end
                endcase
                acc_next  = cp_t'(text_byte & mask);
                fl_next   = n;
                open_next = 1'b1;
            end
        end
        if (final_byte && open_next)
        begin
            if (cnt == 2'd0)
            begin
                ent.cp0 = acc_next;
            end
            else
            begin
                ent.cp1 = acc_next;
            end
            cnt       = cnt + 2'd1;
            open_next = 1'b0;
            fl_next   = 3'd0;
            acc_next  = '0;
        end
        ent.two = (cnt == 2'd2);
    end

    assign push       = take && (cnt != 2'd0);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fl_reg   <= '0;
            open_reg <= 1'b0;
        end
        else if (take)
        begin
            acc_reg  <= acc_next;
            fl_reg   <= fl_next;
            open_reg <= open_next;
        end
    end

endmodule

// ===== hw/rtl/u8sd_queue.sv =====
// Short queue of result entries between the front end and the output stage.
module u8sd_queue #(
    parameter int DEPTH = u8sd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  u8sd_pkg::res_entry_t push_entry,
    input  logic                 pop,
    output u8sd_pkg::q_head_t    head,
    output logic                 full
);
    import u8sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_reg;
    logic [PTR_W-1:0]     wr_next;
    logic [PTR_W-1:0]     rd_reg;
    logic [PTR_W-1:0]     rd_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_reg];

endmodule

// ===== hw/rtl/u8sd_back.sv =====
// Output stage: sends the one or two code points of each queued entry.
module u8sd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  u8sd_pkg::q_head_t head,
    output logic              pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,
    output logic              m_axis_tlast
);
    import u8sd_pkg::*;

    logic phase_reg;
    logic phase_next;
    cp_t  cp;

    assign cp            = phase_reg ? head.entry.cp1 : head.entry.cp0;
    assign m_axis_tvalid = head.valid;
    assign m_axis_tdata  = {1'b0, cp};
    assign m_axis_tlast  = phase_reg || !head.entry.two;
    assign pop           = head.valid && m_axis_tready && m_axis_tlast;

    always_comb
    begin
        phase_next = phase_reg;
        if (head.valid && m_axis_tready)
        begin
            phase_next = !m_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front end, result queue and output stage.
//
//  Channel  Dir  tdata (low bit up)       tlast         tuser
//  s_axis   in   text_byte[7:0]           final_byte    -
//  m_axis   out  code_point[30:0], pad 0  last_of_run   -
//
// One byte is accepted per cycle while the result queue has room.
// A byte gives zero, one or two code points; the output sends one per cycle while
// m_axis_tready is high, so a run of two-result bytes fills the queue and then holds s_axis_tready low.
// Reset clears the open sequence, the queue pointers and the output phase.
// A stall on m_axis backs up through the queue without losing any transfer.
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = u8sd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // code_point[30:0], zero at bit 31
    output logic        m_axis_tlast
);
    import u8sd_pkg::*;

    logic       take;
    logic       push;
    logic       pop;
    logic       full;
    res_entry_t push_entry;
    q_head_t    head;

    assign s_axis_tready = !full;
    assign take          = s_axis_tvalid && !full;

    u8sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .text_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full)
    );

    u8sd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("queue full with no pending output");

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("final byte produced no result");

    a_pair_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("first of a result pair not followed by the second");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && $past(push) && $past(take)) |-> !m_axis_tdata[31])
        else $error("pad bit of output data set");

endmodule
